// File: rtl/dfir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfir_pkg: shared types and constants of the decimating Q15 FIR filter
// Holds widths, the coefficient table, the controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dfir_pkg;

  localparam int TAPS     = 19;
  localparam int IDX_W    = $clog2(TAPS);
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = 21;
  localparam int DEC_W    = 8;

  localparam logic [DEC_W-1:0] DEC_RESET = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_DONE
  } dfir_state_t;

  typedef struct packed {
    logic accept;    // store the offered sample and advance the counters
    logic mac_step;  // issue one tap product
    logic load_out;  // copy the finished sum into the output register
  } dfir_cmd_t;

  typedef struct packed {
    logic emit;      // the offered item completes a decimation period
    logic last_tap;  // the tap being issued is the oldest one
  } dfir_sts_t;

  // Q15 coefficients, truncated toward zero; tap 0 weights the newest sample.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [IDX_W-1:0] k);
    logic signed [COEF_W-1:0] c;
    case (k)
      5'd0:    c = 16'sd2430;
      5'd1:    c = 16'sd1071;
      5'd2:    c = 16'sd1266;
      5'd3:    c = 16'sd1456;
      5'd4:    c = 16'sd1631;
      5'd5:    c = 16'sd1785;
      5'd6:    c = 16'sd1914;
      5'd7:    c = 16'sd2010;
      5'd8:    c = 16'sd2068;
      5'd9:    c = 16'sd2088;
      5'd10:   c = 16'sd2068;
      5'd11:   c = 16'sd2010;
      5'd12:   c = 16'sd1914;
      5'd13:   c = 16'sd1785;
      5'd14:   c = 16'sd1631;
      5'd15:   c = 16'sd1456;
      5'd16:   c = 16'sd1266;
      5'd17:   c = 16'sd1071;
      5'd18:   c = 16'sd2430;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/dfir_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfir_datapath: sample window, decimation counter and shared MAC unit
// One multiplier visits the taps one per cycle; the product is registered,
// then floor-shifted, saturated to Q15 and added to the running sum.
// ----------------------------------------------------------------------------
module dfir_datapath (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  dfir_pkg::dfir_cmd_t                     cmd,
  output dfir_pkg::dfir_sts_t                     sts,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0]    sample_in,
  input  logic                                    cfg_we,
  input  logic        [dfir_pkg::DEC_W-1:0]       cfg_wdata,
  output logic signed [dfir_pkg::ACC_W-1:0]       filtered_value
);
  import dfir_pkg::*;

  logic signed [SAMPLE_W-1:0] win_r [TAPS];
  logic [IDX_W-1:0]           wp_r;
  logic [IDX_W-1:0]           rd_idx_r;
  logic [IDX_W-1:0]           tap_r;
  logic [DEC_W-1:0]           factor_r;
  logic [DEC_W-1:0]           count_r;
  logic [DEC_W-1:0]           count_inc;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_vld_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [ACC_W-1:0]    out_data_r;
  logic signed [PROD_W-16:0]  prod_sh;
  logic signed [SAMPLE_W-1:0] prod_sat;
  logic [IDX_W-1:0]           wp_nxt;
  logic [IDX_W-1:0]           rd_idx_nxt;

  assign count_inc    = count_r + 1'b1;
  assign sts.emit     = (count_inc >= factor_r) || (count_inc == '0);
  assign sts.last_tap = (tap_r == IDX_W'(TAPS - 1));

  assign wp_nxt     = (wp_r == IDX_W'(TAPS - 1)) ? '0 : wp_r + 1'b1;
  assign rd_idx_nxt = (rd_idx_r == '0) ? IDX_W'(TAPS - 1) : rd_idx_r - 1'b1;

  // Floor shift by 15, then clamp to Q15 when the two top bits disagree.
  assign prod_sh = prod_r[PROD_W-1:15];
  always_comb begin
    if (prod_sh[PROD_W-15-1] != prod_sh[PROD_W-15-2]) begin
      prod_sat = prod_sh[PROD_W-15-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                       : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      prod_sat = prod_sh[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) win_r[i] <= '0;
      wp_r       <= '0;
      count_r    <= '0;
      factor_r   <= DEC_RESET;
      prod_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        factor_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        win_r[wp_r] <= sample_in;
        wp_r        <= wp_nxt;
        count_r     <= sts.emit ? '0 : count_inc;
      end
      prod_vld_r <= cmd.mac_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_idx_r <= wp_r;
      tap_r    <= '0;
      acc_r    <= '0;
    end else begin
      if (cmd.mac_step) begin
        rd_idx_r <= rd_idx_nxt;
        tap_r    <= tap_r + 1'b1;
      end
      if (prod_vld_r) begin
        acc_r <= acc_r + ACC_W'(prod_sat);
      end
    end
    if (cmd.mac_step) begin
      prod_r <= win_r[rd_idx_r] * coef_at(tap_r);
    end
    if (cmd.load_out) begin
      out_data_r <= acc_r;
    end
  end

  assign filtered_value = out_data_r;

endmodule

// File: rtl/dfir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfir_ctrl: sequencing state machine of the decimating FIR filter
// Accepts items, runs the tap sweep when a result is due and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module dfir_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dfir_pkg::dfir_sts_t  sts,
  output dfir_pkg::dfir_cmd_t  cmd
);
  import dfir_pkg::*;

  dfir_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && sts.emit) state_nxt = ST_MAC;
      end
      ST_MAC: begin
        if (sts.last_tap) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = !out_valid_r || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out)             out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/decimating_fir_q15.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimating_fir_q15: 19-tap decimating FIR filter in Q15
// Stores each sample in a 19-entry window and emits one filtered sum every
// N samples, N being the decimation register.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (in_valid/in_ready, in_sample_in) carry one signed Q15
//   sample each. Result items (out_valid/out_ready, out_filtered_value)
//   carry the 21-bit signed sum of the 19 saturated tap products.
//   cfg_we/cfg_wdata write the decimation factor (reset value 10; zero acts
//   like one). Write it only while the filter is idle.
//   An item that does not complete a decimation period is taken and the
//   filter stays ready for the next one. An item that completes a period
//   starts a sweep of the single multiply-accumulate unit over the 19
//   taps, one tap per cycle, then adds the last registered product and
//   hands off the sum; no new item is taken until the sum is handed off.
//   The result sits in an output register, so a stalled receiver does not
//   block new items until a second result is ready to be written; then the
//   filter waits until the first result is taken.
//   Reset (rst_n low, synchronous) clears the window to zeros, the write
//   position and the decimation count, and restores the factor to 10.
// ----------------------------------------------------------------------------
module decimating_fir_q15 (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [dfir_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dfir_pkg::ACC_W-1:0]    out_filtered_value,
  input  logic                                 cfg_we,
  input  logic        [dfir_pkg::DEC_W-1:0]    cfg_wdata
);
  import dfir_pkg::*;

  dfir_cmd_t cmd;
  dfir_sts_t sts;

  // The controller sequences the tap sweep and owns both handshakes.
  dfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the window, the counters and the MAC unit.
  dfir_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .sample_in      (in_sample_in),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .filtered_value (out_filtered_value)
  );

endmodule

// File: rtl/dfir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfir_checker: port-level checks of the decimating FIR filter
// Watches reset behavior, result timing and the range of the sums.
// ----------------------------------------------------------------------------
module dfir_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [dfir_pkg::ACC_W-1:0]    out_filtered_value
);
  import dfir_pkg::*;

  // After reset the filter is ready and holds no result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("filter not idle after reset");

  // A result waiting on the receiver stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered_value))
    else $error("stalled result changed");

  // A sum needs the full tap sweep, so it never follows an item directly.
  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after an item");

  // Every sum lies within 19 full-scale Q15 values.
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_filtered_value >= -21'sd622592) &&
                  (out_filtered_value <= 21'sd622592))
    else $error("sum out of range");

endmodule

bind decimating_fir_q15 dfir_checker u_dfir_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_value (out_filtered_value)
);

// File: verif/decimating_fir_q15_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimating_fir_q15_tb: self-checking bench for the decimating Q15 FIR
// A directed table covers the field extremes, factor zero and factor one,
// the largest factor, and a factor lowered below a running count. Random
// phases follow, each at a new decimation factor. An in-bench predictor of
// the window, the tap sum and the decimation count checks every result
// item in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module decimating_fir_q15_tb;
  import dfir_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_ITEMS     = 1400;
  // A sum is handed off at the end of the tap sweep for the item that completes
  // a period, so this many quiet cycles means nothing is still in flight.
  localparam int SETTLE_CYCLES    = 30;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RUN_LIMIT_NS     = 5_000_000;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // One row of the directed table. A register write carries the factor in
  // the low bits of value. A sample row may carry a hand-typed sum; when
  // typed is low the sum comes from the predictor instead.
  typedef struct packed {
    row_kind_t                  kind;
    logic [SAMPLE_W-1:0]        value;
    logic                       typed;
    logic signed [ACC_W-1:0]    sum;
  } stim_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [ACC_W-1:0]    out_filtered_value;
  logic                       cfg_we;
  logic [DEC_W-1:0]           cfg_wdata;

  // Predictor state: the sample window, the slot the next sample fills,
  // the decimation count and the factor last written.
  logic signed [SAMPLE_W-1:0] window_q [TAPS];
  int unsigned                wr_pos;
  logic [DEC_W-1:0]           dec_count;
  logic [DEC_W-1:0]           dec_factor;

  // Q15 weights by sample age, age 0 being the newest sample.
  logic signed [COEF_W-1:0] tap_coef [TAPS] = '{
    16'sd2430, 16'sd1071, 16'sd1266, 16'sd1456, 16'sd1631, 16'sd1785,
    16'sd1914, 16'sd2010, 16'sd2068, 16'sd2088, 16'sd2068, 16'sd2010,
    16'sd1914, 16'sd1785, 16'sd1631, 16'sd1456, 16'sd1266, 16'sd1071,
    16'sd2430
  };

  // Sums still owed by the filter, oldest first.
  logic signed [ACC_W-1:0] expected_sums [$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  phase_count  = 0;
  int  holds_done   = 0;
  bit  long_hold_req = 1'b0;

  stim_row_t directed_rows [19] = '{
    // Factor one right after reset: the first sample emits alone in the
    // window, so the sum is just floor(32767 * 2430 / 32768).
    '{ROW_CFG,    16'd1,    1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b1, 21'sd2429},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h0001, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'hFFFF, 1'b0, 21'sd0},
    // Factor zero behaves like one.
    '{ROW_CFG,    16'd0,    1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h5555, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'hAAAA, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 21'sd0},
    // Largest factor: four samples leave the count at four, no result.
    '{ROW_CFG,    16'd255,  1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h7FFF, 1'b0, 21'sd0},
    // Factor lowered below the running count: the next sample emits at
    // once and the count restarts, so the one after it does not.
    '{ROW_CFG,    16'd2,    1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h1234, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'hFEDC, 1'b0, 21'sd0},
    '{ROW_SAMPLE, 16'h0F0F, 1'b0, 21'sd0},
    '{ROW_CFG,    16'd10,   1'b0, 21'sd0}
  };

  decimating_fir_q15 dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample_in       (in_sample_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered_value (out_filtered_value),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // Stores one accepted sample, sums the 19 saturated tap products fresh,
  // and advances the decimation count. Returns 1 when the sample completes
  // a period and so causes a result item.
  function automatic bit advance_filter(input logic signed [SAMPLE_W-1:0] s,
                                        output logic signed [ACC_W-1:0] sum_out);
    int                 acc;
    int unsigned        age_slot;
    int                 k;
    logic signed [31:0] prod;
    logic signed [31:0] shifted;
    window_q[wr_pos] = s;
    acc = 0;
    for (k = 0; k < TAPS; k++) begin
      age_slot = (wr_pos + TAPS - k) % TAPS;
      prod     = window_q[age_slot] * tap_coef[k];
      // Arithmetic shift floors toward minus infinity, as the datapath does.
      shifted  = prod >>> 15;
      if (shifted > 32767) shifted = 32767;
      if (shifted < -32768) shifted = -32768;
      acc += shifted;
    end
    wr_pos    = (wr_pos + 1) % TAPS;
    sum_out   = acc[ACC_W-1:0];
    dec_count = dec_count + 1'b1;
    // A factor of zero makes every sample emit, since the count is always
    // at least zero.
    if (dec_count >= dec_factor || dec_count == '0) begin
      dec_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offers one sample and holds it until the filter takes it. Entered and
  // left at a falling edge, so back-to-back calls keep valid high.
  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s,
                              input logic typed,
                              input logic signed [ACC_W-1:0] typed_sum);
    logic signed [ACC_W-1:0] predicted;
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    if (advance_filter(s, predicted)) begin
      expected_sums.push_back(typed ? typed_sum : predicted);
    end
    @(negedge clk);
  endtask

  task automatic pause_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // The factor may only change while the filter is idle: wait for every
  // owed result, then long enough for any sweep to have finished.
  task automatic write_factor(input logic [DEC_W-1:0] factor);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_sums.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= factor;
    dec_factor  = factor;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Draws one sample. Style 0 mixes full-range values, extremes, values
  // near zero, single bits and repeats; styles 1 and 2 hold the window near
  // one extreme, and style 3 swings between the two extremes.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input int style, input logic signed [SAMPLE_W-1:0] prev);
    int pick;
    pick = $urandom_range(0, 9);
    case (style)
      1: return (pick == 0) ? SAMPLE_W'($urandom) : 16'sh7FFF;
      2: return (pick == 0) ? SAMPLE_W'($urandom) : 16'sh8000;
      3: return (prev == 16'sh7FFF) ? 16'sh8000 : 16'sh7FFF;
      default: begin
        case (pick)
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
          3: return SAMPLE_W'(16'h1 << $urandom_range(0, 15));
          4: return prev;
          default: return SAMPLE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  // Result side: checks each accepted result item against the oldest
  // owed sum.
  always @(posedge clk) begin : result_check
    logic signed [ACC_W-1:0] want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result item: filtered_value %0d", out_filtered_value);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        results_seen++;
        if (out_filtered_value !== want) begin
          $error("filtered_value mismatch: expected %0d, actual %0d",
                 want, out_filtered_value);
          fail_count++;
        end
      end
    end
  end

  // Receiver: runs through segments of random length, each with its own
  // stall pattern (always ready, coin flip, mostly stalled, mostly ready).
  // On request it holds off for a long counted stretch so that the output
  // register fills and the filter has to stall its input.
  initial begin : result_receiver
    int seg_len;
    int mode;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      seg_len = $urandom_range(20, 200);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk);
        if (long_hold_req) begin
          long_hold_req = 1'b0;
          holds_done++;
          out_ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 7) == 0);
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Sender: the directed table first, then random phases, each opening
  // with a new factor written while the filter is idle.
  initial begin : sample_sender
    logic [DEC_W-1:0]           factor;
    logic signed [SAMPLE_W-1:0] s;
    int                         style;
    int                         phase_items;
    int                         burst_left;
    int                         gap;
    int                         pick;
    int                         i;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    for (i = 0; i < TAPS; i++) window_q[i] = '0;
    wr_pos     = 0;
    dec_count  = '0;
    dec_factor = DEC_RESET;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_factor(directed_rows[r].value[DEC_W-1:0]);
      end else begin
        gap = $urandom_range(0, 3);
        if (gap > 0) pause_input(gap);
        offer_sample(directed_rows[r].value, directed_rows[r].typed,
                     directed_rows[r].sum);
      end
    end

    // The first three phases pin the factor to one, its maximum and zero;
    // later ones lean toward small factors so that results come often.
    s          = '0;
    burst_left = 0;
    while (items_sent < RANDOM_ITEMS + 14) begin
      case (phase_count)
        0: factor = 8'd1;
        1: factor = 8'd255;
        2: factor = 8'd0;
        default: begin
          pick = $urandom_range(0, 99);
          if (pick < 45)      factor = DEC_W'($urandom_range(1, 4));
          else if (pick < 80) factor = DEC_W'($urandom_range(5, 20));
          else if (pick < 95) factor = DEC_W'($urandom_range(21, 60));
          else                factor = DEC_W'($urandom_range(61, 255));
        end
      endcase
      write_factor(factor);

      // With factor one every item emits, which makes a long receiver
      // hold-off back the filter up quickly.
      if (phase_count == 0 || (factor == 8'd1 && $urandom_range(0, 3) == 0)) begin
        long_hold_req = 1'b1;
      end

      style = (phase_count < 3) ? 0 : $urandom_range(0, 5);
      if (style > 3) style = 0;
      phase_items = $urandom_range(10, 50) +
                    ((factor > 20) ? int'(factor) + 1 : int'(factor) * $urandom_range(2, 6));

      for (i = 0; i < phase_items && items_sent < RANDOM_ITEMS + 14; i++) begin
        if (burst_left == 0) begin
          pause_input($urandom_range(1, 12));
          // Now and then a long burst gives a stretch with no sender gaps.
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
        end
        s = pick_sample(style, s);
        offer_sample(s, 1'b0, '0);
        burst_left--;
      end
      phase_count++;
    end

    // Drain: every owed sum must arrive, then a quiet stretch catches
    // any stray result.
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Ran %0d samples in %0d factor phases (factors 0, 1, 255 and random),",
             items_sent, phase_count);
    $display("checked %0d filtered sums, with %0d long receiver hold-offs.",
             results_seen, holds_done);
    if (fail_count == 0 && expected_sums.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

// File: decimating_fir_q15.f
rtl/dfir_pkg.sv
rtl/dfir_datapath.sv
rtl/dfir_ctrl.sv
rtl/decimating_fir_q15.sv
rtl/dfir_checker.sv
verif/decimating_fir_q15_tb.sv
